@@ rtl/mbce_pkg.sv @@
package mbce_pkg;

  // Default values of the top-level parameters.
  localparam int MaxWidthDef     = 256;
  localparam int CoordBitsDef    = 10;
  localparam int ColourLevelsDef = 4;

  // Fixed field widths, lane count and maximum block height.
  localparam int ByteBits   = 8;
  localparam int Lanes      = 8;
  localparam int LaneBits   = 3;
  localparam int WidthBits  = 9;
  localparam int HeightBits = 9;
  localparam int RowBits    = 8;
  localparam int BprBits    = 7;
  localparam int ColourBits = 2;
  localparam int ColCmpBits = 10;
  localparam int MaxHeight  = 256;
  localparam int ApbAddrBits = 5;
  localparam int ApbDataBits = 32;

  // Register reset values.
  localparam int WidthReset     = 8;
  localparam int HeightReset    = 8;
  localparam int ClipRightReset = 511;
  localparam int ForeReset      = 3;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_BLOCK_WIDTH  = 3'd2,
    REG_BLOCK_HEIGHT = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_RIGHT   = 3'd5,
    REG_BACK_COLOUR  = 3'd6,
    REG_FORE_COLOUR  = 3'd7
  } cfg_reg_e;

  // Per-byte flags carried from the sequencer to the lanes and merge stage.
  typedef struct packed {
    logic enable;      // clip window non-empty and byte column inside the row
    logic last_block;  // this byte is the last one of the block
  } byte_flags_t;

endpackage

@@ rtl/mono_bitmap_color_expander_unit.sv @@
// Channel        Dir  Handshake              Payload
// s_axis         in   tvalid/tready          tdata: bitmap_byte; tuser: first_of_block
// m_axis         out  tvalid/tready          tdata: pixel_x, pixel_y, pixel_colour;
//                                            tlast: last_of_byte; tuser: last_of_block
// apb            in   psel/penable/pready    eight configuration registers at 4*i
//
// Eight combinational lanes evaluate all pixels of a byte; the merge stage then sends
// one pixel per cycle unless m_axis stalls, and none for a byte with no visible pixels.
// An accepted byte is registered in the sequencer stage, its lane results are loaded
// into the merge stage, and its first pixel then enters the output register (tvalid).
// Reset clears counters, valids and registers to their defaults. An output stall holds
// the pending byte; one more waits in the sequencer stage before s_axis_tready drops.
module mono_bitmap_color_expander_unit #(
  parameter int MaxWidth     = mbce_pkg::MaxWidthDef,
  parameter int CoordBits    = mbce_pkg::CoordBitsDef,
  parameter int ColourLevels = mbce_pkg::ColourLevelsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // bitmap_byte [7:0]
  input  logic [mbce_pkg::ByteBits-1:0]          s_axis_tdata,
  // first_of_block [0]
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pixel_x, pixel_y, pixel_colour from bit 0 up, zero filled to bytes
  output logic [((2*CoordBits+mbce_pkg::ColourBits+7)/8)*8-1:0] m_axis_tdata,
  output logic                                   m_axis_tlast,
  // last_of_block [0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mbce_pkg::ApbAddrBits-1:0]       paddr,
  input  logic [mbce_pkg::ApbDataBits-1:0]       pwdata,
  output logic [mbce_pkg::ApbDataBits-1:0]       prdata,
  output logic                                   pready
);
  import mbce_pkg::*;

  localparam int OutBits  = ((2*CoordBits+ColourBits+7)/8)*8;
  localparam int EffWidth = (MaxWidth < 511) ? MaxWidth : 511;
  localparam int BprMax   = (EffWidth + 7) / 8;
  localparam int ColBits  = (BprMax > 1) ? $clog2(BprMax) : 1;

  logic [CoordBits-1:0]  origin_x_q, origin_y_q, clip_left_q, clip_right_q;
  logic [WidthBits-1:0]  width_q;
  logic [HeightBits-1:0] height_q;
  logic [ColourBits-1:0] back_q, fore_q;

  cfg_reg_e              reg_idx;
  logic                  cfg_write;
  logic [WidthBits-1:0]  width_eff;
  logic [HeightBits-1:0] height_eff;
  logic [ColourBits-1:0] fore_sat, back_sat;
  logic                  clip_ok;

  logic                  a_valid, a_ready;
  logic [ByteBits-1:0]   a_data;
  logic [ColBits-1:0]    a_col;
  logic [CoordBits-1:0]  a_y;
  byte_flags_t           a_flags;

  logic [Lanes-1:0]                  lane_hit;
  logic [Lanes-1:0][CoordBits-1:0]   lane_x;
  logic [Lanes-1:0][ColourBits-1:0]  lane_colour;

  logic [CoordBits-1:0]  out_x, out_y;
  logic [ColourBits-1:0] out_colour;

  // Configuration register file.
  assign reg_idx   = cfg_reg_e'(paddr[ApbAddrBits-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      width_q      <= WidthBits'(WidthReset);
      height_q     <= HeightBits'(HeightReset);
      clip_left_q  <= '0;
      clip_right_q <= CoordBits'(ClipRightReset);
      back_q       <= '0;
      fore_q       <= ColourBits'(ForeReset);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ORIGIN_X:     origin_x_q   <= pwdata[CoordBits-1:0];
        REG_ORIGIN_Y:     origin_y_q   <= pwdata[CoordBits-1:0];
        REG_BLOCK_WIDTH:  width_q      <= pwdata[WidthBits-1:0];
        REG_BLOCK_HEIGHT: height_q     <= pwdata[HeightBits-1:0];
        REG_CLIP_LEFT:    clip_left_q  <= pwdata[CoordBits-1:0];
        REG_CLIP_RIGHT:   clip_right_q <= pwdata[CoordBits-1:0];
        REG_BACK_COLOUR:  back_q       <= pwdata[ColourBits-1:0];
        REG_FORE_COLOUR:  fore_q       <= pwdata[ColourBits-1:0];
        default:          ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:     prdata = ApbDataBits'(origin_x_q);
      REG_ORIGIN_Y:     prdata = ApbDataBits'(origin_y_q);
      REG_BLOCK_WIDTH:  prdata = ApbDataBits'(width_q);
      REG_BLOCK_HEIGHT: prdata = ApbDataBits'(height_q);
      REG_CLIP_LEFT:    prdata = ApbDataBits'(clip_left_q);
      REG_CLIP_RIGHT:   prdata = ApbDataBits'(clip_right_q);
      REG_BACK_COLOUR:  prdata = ApbDataBits'(back_q);
      REG_FORE_COLOUR:  prdata = ApbDataBits'(fore_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp the geometry and colours to their legal ranges.
  always_comb begin
    if (width_q == '0) begin
      width_eff = WidthBits'(1);
    end else if (32'(width_q) > MaxWidth) begin
      width_eff = WidthBits'(MaxWidth);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = HeightBits'(1);
    end else if (32'(height_q) > MaxHeight) begin
      height_eff = HeightBits'(MaxHeight);
    end else begin
      height_eff = height_q;
    end
    fore_sat = (32'(fore_q) >= ColourLevels) ? ColourBits'(ColourLevels - 1) : fore_q;
    back_sat = (32'(back_q) >= ColourLevels) ? ColourBits'(ColourLevels - 1) : back_q;
    clip_ok  = signed'(clip_left_q) <= signed'(clip_right_q);
  end

  mbce_sequencer #(
    .CoordBits(CoordBits),
    .ColBits  (ColBits)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_first_i (s_axis_tuser),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .origin_y_i (origin_y_q),
    .clip_ok_i  (clip_ok),
    .a_valid_o  (a_valid),
    .a_ready_i  (a_ready),
    .a_data_o   (a_data),
    .a_col_o    (a_col),
    .a_y_o      (a_y),
    .a_flags_o  (a_flags)
  );

  // One lane per bitmap bit; lane 0 is the leftmost pixel (bit 7).
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    mbce_lane #(
      .CoordBits(CoordBits),
      .ColBits  (ColBits),
      .Lane     (g)
    ) u_lane (
      .enable_i     (a_flags.enable),
      .data_bit_i   (a_data[ByteBits-1-g]),
      .col_base_i   (a_col),
      .width_i      (width_eff),
      .origin_x_i   (origin_x_q),
      .clip_left_i  (clip_left_q),
      .clip_right_i (clip_right_q),
      .fore_i       (fore_sat),
      .back_i       (back_sat),
      .hit_o        (lane_hit[g]),
      .x_o          (lane_x[g]),
      .colour_o     (lane_colour[g])
    );
  end

  mbce_merge #(
    .CoordBits(CoordBits)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .a_valid_i        (a_valid),
    .a_ready_o        (a_ready),
    .hit_i            (lane_hit),
    .x_i              (lane_x),
    .colour_i         (lane_colour),
    .y_i              (a_y),
    .flags_i          (a_flags),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_x_o          (out_x),
    .out_y_o          (out_y),
    .out_colour_o     (out_colour),
    .out_last_byte_o  (m_axis_tlast),
    .out_last_block_o (m_axis_tuser)
  );

  assign m_axis_tdata = OutBits'({out_colour, out_y, out_x});

endmodule

@@ rtl/mbce_lane.sv @@
module mbce_lane #(
  parameter int CoordBits = mbce_pkg::CoordBitsDef,
  parameter int ColBits   = 5,
  parameter int Lane      = 0
) (
  input  logic                                    enable_i,
  input  logic                                    data_bit_i,
  input  logic [ColBits-1:0]                      col_base_i,
  input  logic [mbce_pkg::WidthBits-1:0]          width_i,
  input  logic [CoordBits-1:0]                    origin_x_i,
  input  logic [CoordBits-1:0]                    clip_left_i,
  input  logic [CoordBits-1:0]                    clip_right_i,
  input  logic [mbce_pkg::ColourBits-1:0]         fore_i,
  input  logic [mbce_pkg::ColourBits-1:0]         back_i,
  output logic                                    hit_o,
  output logic [CoordBits-1:0]                    x_o,
  output logic [mbce_pkg::ColourBits-1:0]         colour_o
);
  import mbce_pkg::*;

  // Wide enough for origin plus column without overflow.
  localparam int XBits = ((CoordBits > ColCmpBits) ? CoordBits : ColCmpBits) + 2;

  logic [ColBits+LaneBits-1:0] col;
  logic [ColCmpBits-1:0]       col_ext;
  logic signed [XBits-1:0]     x_full;
  logic signed [XBits-1:0]     cl_ext;
  logic signed [XBits-1:0]     cr_ext;
  logic                        in_row;

  // Column of this lane's pixel inside the bitmap row.
  assign col     = {col_base_i, LaneBits'(Lane)};
  assign col_ext = ColCmpBits'(col);
  assign in_row  = col_ext < ColCmpBits'(width_i);

  // Display x and the clip compare, all signed.
  assign x_full = signed'({{(XBits-CoordBits){origin_x_i[CoordBits-1]}}, origin_x_i})
                + signed'(XBits'(col_ext));
  assign cl_ext = signed'({{(XBits-CoordBits){clip_left_i[CoordBits-1]}}, clip_left_i});
  assign cr_ext = signed'({{(XBits-CoordBits){clip_right_i[CoordBits-1]}}, clip_right_i});

  assign hit_o    = enable_i && in_row && (x_full >= cl_ext) && (x_full <= cr_ext);
  assign x_o      = x_full[CoordBits-1:0];
  assign colour_o = data_bit_i ? fore_i : back_i;

endmodule

@@ rtl/mbce_sequencer.sv @@
module mbce_sequencer #(
  parameter int CoordBits = mbce_pkg::CoordBitsDef,
  parameter int ColBits   = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mbce_pkg::ByteBits-1:0]      in_data_i,
  input  logic                               in_first_i,
  input  logic [mbce_pkg::WidthBits-1:0]     width_i,
  input  logic [mbce_pkg::HeightBits-1:0]    height_i,
  input  logic [CoordBits-1:0]               origin_y_i,
  input  logic                               clip_ok_i,
  output logic                               a_valid_o,
  input  logic                               a_ready_i,
  output logic [mbce_pkg::ByteBits-1:0]      a_data_o,
  output logic [ColBits-1:0]                 a_col_o,
  output logic [CoordBits-1:0]               a_y_o,
  output mbce_pkg::byte_flags_t              a_flags_o
);
  import mbce_pkg::*;

  logic [ColBits-1:0]  col_q, col_d;
  logic [RowBits-1:0]  row_q, row_d;
  logic                a_valid_q, a_valid_d;
  logic [ByteBits-1:0] a_data_q;
  logic [ColBits-1:0]  a_col_q;
  logic [CoordBits-1:0] a_y_q;
  byte_flags_t         a_flags_q;

  logic                accept;
  logic [ColBits-1:0]  cur_col;
  logic [RowBits-1:0]  cur_row;
  logic [BprBits-1:0]  bpr;
  logic [BprBits-1:0]  col_inc;
  logic [HeightBits-1:0] row_inc;
  logic                row_end;
  logic                block_end;
  byte_flags_t         flags;

  assign in_ready_o = !a_valid_q || a_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Counter update for the byte being accepted.
  always_comb begin
    cur_col   = in_first_i ? '0 : col_q;
    cur_row   = in_first_i ? '0 : row_q;
    bpr       = BprBits'((WidthBits+1)'(width_i) + (WidthBits+1)'(7) >> 3);
    col_inc   = BprBits'(cur_col) + BprBits'(1);
    row_inc   = HeightBits'(cur_row) + HeightBits'(1);
    row_end   = col_inc >= bpr;
    block_end = row_inc >= height_i;
    flags.last_block = row_end && block_end;
    flags.enable     = clip_ok_i && (BprBits'(cur_col) < bpr);
    col_d     = col_q;
    row_d     = row_q;
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
      if (row_end) begin
        col_d = '0;
        row_d = block_end ? '0 : row_inc[RowBits-1:0];
      end else begin
        col_d = col_inc[ColBits-1:0];
        row_d = cur_row;
      end
    end else if (a_ready_i) begin
      a_valid_d = 1'b0;
    end
  end

  // Counters and stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= a_valid_d;
    end
  end

  // Byte payload for the lanes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_data_q  <= in_data_i;
      a_col_q   <= cur_col;
      a_y_q     <= origin_y_i + CoordBits'(cur_row);
      a_flags_q <= flags;
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_data_o  = a_data_q;
  assign a_col_o   = a_col_q;
  assign a_y_o     = a_y_q;
  assign a_flags_o = a_flags_q;

endmodule

@@ rtl/mbce_merge.sv @@
module mbce_merge #(
  parameter int CoordBits = mbce_pkg::CoordBitsDef
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  a_valid_i,
  output logic                                                  a_ready_o,
  input  logic [mbce_pkg::Lanes-1:0]                            hit_i,
  input  logic [mbce_pkg::Lanes-1:0][CoordBits-1:0]             x_i,
  input  logic [mbce_pkg::Lanes-1:0][mbce_pkg::ColourBits-1:0]  colour_i,
  input  logic [CoordBits-1:0]                                  y_i,
  input  mbce_pkg::byte_flags_t                                 flags_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [CoordBits-1:0]                                  out_x_o,
  output logic [CoordBits-1:0]                                  out_y_o,
  output logic [mbce_pkg::ColourBits-1:0]                       out_colour_o,
  output logic                                                  out_last_byte_o,
  output logic                                                  out_last_block_o
);
  import mbce_pkg::*;

  logic [Lanes-1:0]                  mask_q, mask_d;
  logic [Lanes-1:0][CoordBits-1:0]   x_q;
  logic [Lanes-1:0][ColourBits-1:0]  colour_q;
  logic [CoordBits-1:0]              y_q;
  logic                              last_block_q;
  logic                              out_valid_q, out_valid_d;
  logic [CoordBits-1:0]              out_x_q;
  logic [CoordBits-1:0]              out_y_q;
  logic [ColourBits-1:0]             out_colour_q;
  logic                              out_last_byte_q;
  logic                              out_last_block_q;

  logic [LaneBits-1:0] sel;
  logic [Lanes-1:0]    rest;
  logic [Lanes-1:0]    remain;
  logic                out_free;
  logic                pop;
  logic                load;

  // Pick the leftmost pending pixel and decide whether the next byte loads.
  always_comb begin
    sel = '0;
    for (int i = Lanes - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = LaneBits'(i);
      end
    end
    rest        = mask_q & ~(Lanes'(1) << sel);
    out_free    = !out_valid_q || out_ready_i;
    pop         = (|mask_q) && out_free;
    remain      = pop ? rest : mask_q;
    a_ready_o   = remain == '0;
    load        = a_valid_i && a_ready_o;
    mask_d      = load ? hit_i : remain;
    out_valid_d = pop ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  end

  // Pending mask and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Lane results of the byte in progress.
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q          <= x_i;
      colour_q     <= colour_i;
      y_q          <= y_i;
      last_block_q <= flags_i.last_block;
    end
  end

  // Output register: one pixel transaction at a time.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_x_q          <= x_q[sel];
      out_y_q          <= y_q;
      out_colour_q     <= colour_q[sel];
      out_last_byte_q  <= rest == '0;
      out_last_block_q <= (rest == '0) && last_block_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign out_colour_o     = out_colour_q;
  assign out_last_byte_o  = out_last_byte_q;
  assign out_last_block_o = out_last_block_q;

endmodule
